>>> hdl/mmad_pkg.sv
// ----------------------------------------------------------------------------
// mmad_pkg
// Types and constants shared by the multi-mode 6502 address decoder.
// ----------------------------------------------------------------------------
package mmad_pkg;

  localparam int unsigned HighRamDepth = 32768;
  localparam int unsigned HighRamAw    = $clog2(HighRamDepth);

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_LOW  = 3'd1,
    TGT_HIGH = 3'd2,
    TGT_IO   = 3'd3,
    TGT_CART = 3'd4
  } target_e;

  typedef enum logic [2:0] {
    MODE_OFF = 3'd0,
    MODE_M1  = 3'd1,
    MODE_M2  = 3'd2,
    MODE_M3  = 3'd3,
    MODE_M4  = 3'd4,
    MODE_M5  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MEMORY_MODE   = 2'd0,
    CFG_WINDOW_BEGIN  = 2'd1,
    CFG_WINDOW_END    = 2'd2,
    CFG_WRITE_ENABLES = 2'd3
  } cfg_index_e;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    target_e     target;
    logic [15:0] ext_address;
    logic        screen_dirty;
  } rsp_t;

  // decoded access, handed from the front to the back through the queue
  typedef struct packed {
    logic        is_write;
    target_e     target;
    logic [15:0] ram_index;
    logic [15:0] ext_address;
    logic        dirty;
    logic [7:0]  write_data;
  } job_t;

endpackage

>>> hdl/mmad_stream_if.sv
// ----------------------------------------------------------------------------
// mmad_stream_if
// Valid/ready channel carrying one item of type payload_t.
// ----------------------------------------------------------------------------
interface mmad_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> hdl/mmad_front.sv
// ----------------------------------------------------------------------------
// mmad_front
// Configuration registers and address decode; turns a bus access into a job.
// ----------------------------------------------------------------------------
module mmad_front import mmad_pkg::*; #(
  parameter int unsigned LOW_RAM_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  req_t        req_i,
  output job_t        job_o
);

  logic [2:0]  mode_q;
  logic [15:0] win_begin_q;
  logic [15:0] win_end_q;
  logic [1:0]  wr_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OFF;
      win_begin_q <= '0;
      win_end_q   <= '0;
      wr_en_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_MEMORY_MODE:   mode_q      <= cfg_data_i[2:0];
        CFG_WINDOW_BEGIN:  win_begin_q <= cfg_data_i;
        CFG_WINDOW_END:    win_end_q   <= cfg_data_i;
        CFG_WRITE_ENABLES: wr_en_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [15:0] a;
  logic [15:0] ext;
  logic [15:0] low_addr;
  logic        dirty;
  logic        in_win;
  target_e     tgt;

  assign a      = req_i.address;
  assign in_win = (a >= win_begin_q) && (a < win_end_q);

  always_comb begin
    tgt   = TGT_NONE;
    ext   = '0;
    dirty = 1'b0;
    if (req_i.req_type == REQ_WRITE) begin
      case (mode_e'(mode_q))
        MODE_M1: begin
          if (in_win) begin
            tgt   = TGT_LOW;
            dirty = 1'b1;
          end else if (a < 16'h8000) tgt = TGT_LOW;
          else if (a < 16'hC000) tgt = TGT_HIGH;
          else if (a < 16'hC100) begin
            tgt = TGT_IO;
            ext = {8'h00, a[7:0]};
          end
        end
        MODE_M2: begin
          if (a < 16'h8000) tgt = TGT_LOW;
          else if (a >= 16'h9000 && a < 16'h9400) begin
            tgt = TGT_IO;
            ext = a;
          end else if (a >= 16'h9400 && a < 16'h9800) tgt = TGT_HIGH;
        end
        MODE_M3: begin
          if (a[15:8] == 8'h03) begin
            tgt = TGT_IO;
            ext = a;
          end else if (a < 16'h8000) tgt = TGT_LOW;
          else if (a < 16'hC000) tgt = TGT_HIGH;
        end
        MODE_M4: begin
          if (a < 16'h0400 || (a >= 16'h2800 && a < 16'h3C00)) tgt = TGT_LOW;
          else if (a >= 16'h8000 && a < 16'h9800) begin
            tgt   = TGT_HIGH;
            dirty = (a < win_end_q);
          end else if (a >= 16'hB000 && a < 16'hBC00) begin
            tgt = TGT_IO;
            ext = a;
          end
        end
        MODE_M5: begin
          if (a < 16'h2000) tgt = TGT_LOW;
          else if (a < 16'h4000) begin
            tgt = TGT_IO;
            ext = {13'h0400, a[2:0]};
          end else if (a <= 16'h4016) begin
            tgt = TGT_IO;
            ext = a;
          end else if (a >= 16'h6000 && a < 16'h8000 && wr_en_q[0]) tgt = TGT_LOW;
          else if (a >= 16'h8000 && wr_en_q[1]) begin
            tgt = TGT_IO;
            ext = a;
          end
        end
        default: ;
      endcase
    end else begin
      case (mode_e'(mode_q))
        MODE_M1: begin
          if (a < 16'h8000) tgt = TGT_LOW;
          else if (a < 16'hC000 || a >= 16'hC100) tgt = TGT_HIGH;
          else begin
            tgt = TGT_IO;
            ext = {8'h00, a[7:0]};
          end
        end
        MODE_M2: begin
          if (a < 16'h8000) tgt = TGT_LOW;
          else if (a >= 16'h9000 && a < 16'h9400) begin
            tgt = TGT_IO;
            ext = a;
          end else tgt = TGT_HIGH;
        end
        MODE_M3: begin
          if (a[15:8] == 8'h03) begin
            tgt = TGT_IO;
            ext = a;
          end else if (a < 16'h8000) tgt = TGT_LOW;
          else tgt = TGT_HIGH;
        end
        MODE_M4: begin
          if (a < 16'h8000) tgt = TGT_LOW;
          else if (a >= 16'hB000 && a < 16'hBC00) begin
            tgt = TGT_IO;
            ext = a;
          end else tgt = TGT_HIGH;
        end
        MODE_M5: begin
          if (a >= 16'h8000) begin
            tgt = TGT_CART;
            ext = a;
          end else if (a >= 16'h6000 || a < 16'h2000) tgt = TGT_LOW;
          else if (a < 16'h4000) begin
            tgt = TGT_IO;
            ext = {13'h0400, a[2:0]};
          end else if (a <= 16'h4016) begin
            tgt = TGT_IO;
            ext = a;
          end
        end
        default: ;
      endcase
    end
  end

  // low RAM index: mode 5 mirrors the first 8K every 2K, then wrap at depth
  logic [15:0] mirrored;
  assign mirrored = (mode_q == MODE_M5 && a < 16'h2000) ? (a & 16'h07FF) : a;

  always_comb begin
    if (17'(mirrored) >= 17'(LOW_RAM_DEPTH)) begin
      low_addr = mirrored - 16'(LOW_RAM_DEPTH);
    end else begin
      low_addr = mirrored;
    end
  end

  always_comb begin
    job_o.is_write    = req_i.req_type;
    job_o.target      = tgt;
    job_o.ram_index   = (tgt == TGT_HIGH) ? {1'b0, a[14:0]} : low_addr;
    job_o.ext_address = ext;
    job_o.dirty       = dirty;
    job_o.write_data  = req_i.write_data;
  end

endmodule

>>> hdl/mmad_queue.sv
// ----------------------------------------------------------------------------
// mmad_queue
// Two-entry job queue between the decode front and the RAM back.
// ----------------------------------------------------------------------------
module mmad_queue import mmad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  job_t       entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_job_i;
  end

endmodule

>>> hdl/mmad_back.sv
// ----------------------------------------------------------------------------
// mmad_back
// Holds both RAMs; one job per cycle unless stalled; registers the result.
// ----------------------------------------------------------------------------
module mmad_back import mmad_pkg::*; #(
  parameter int unsigned LOW_RAM_DEPTH = 65536
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic pop_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned LowRamAw = $clog2(LOW_RAM_DEPTH);

  logic [7:0] low_ram  [LOW_RAM_DEPTH];
  logic [7:0] high_ram [HighRamDepth];

  logic [7:0]  low_rdata_q;
  logic [7:0]  high_rdata_q;
  logic        out_valid_q;
  logic        sel_low_q;
  logic        sel_high_q;
  target_e     tgt_q;
  logic [15:0] ext_q;
  logic        dirty_q;
  logic        go;

  logic [LowRamAw-1:0]  low_idx;
  logic [HighRamAw-1:0] high_idx;

  assign go       = job_valid_i && (!out_valid_q || rsp_ready_i);
  assign pop_o    = go;
  assign low_idx  = job_i.ram_index[LowRamAw-1:0];
  assign high_idx = job_i.ram_index[HighRamAw-1:0];

  always_ff @(posedge clk_i) begin
    if (go && job_i.target == TGT_LOW) begin
      if (job_i.is_write) low_ram[low_idx] <= job_i.write_data;
      else                low_rdata_q      <= low_ram[low_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && job_i.target == TGT_HIGH) begin
      if (job_i.is_write) high_ram[high_idx] <= job_i.write_data;
      else                high_rdata_q       <= high_ram[high_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      sel_low_q  <= !job_i.is_write && job_i.target == TGT_LOW;
      sel_high_q <= !job_i.is_write && job_i.target == TGT_HIGH;
      tgt_q      <= job_i.target;
      ext_q      <= job_i.ext_address;
      dirty_q    <= job_i.dirty;
    end
  end

  assign rsp_valid_o        = out_valid_q;
  assign rsp_o.read_data    = sel_low_q ? low_rdata_q : (sel_high_q ? high_rdata_q : 8'h00);
  assign rsp_o.target       = tgt_q;
  assign rsp_o.ext_address  = ext_q;
  assign rsp_o.screen_dirty = dirty_q;

endmodule

>>> hdl/multi_mode_6502_address_decoder.sv
// ----------------------------------------------------------------------------
// multi_mode_6502_address_decoder
// 6502 bus access decoder with five machine maps and two internal RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : one bus access per item (req_type, address, write_data).
//   rsp_o  : one result item per access, in order (read_data, target,
//            ext_address, screen_dirty).
//   cfg_*  : register write port, index 0 memory_mode, 1 window_begin,
//            2 window_end, 3 write_enables. Write only while idle.
// Path: an accepted item is queued, then the back registers its result on rsp_o.
// Throughput: one item per cycle while rsp_o is not held; each RAM has one
//   port, used once per item at the edge the job leaves the two-entry queue,
//   so a read sees any earlier write with no forwarding.
// Stall: while rsp_o is held, the queue fills; req_i.ready drops once both
//   entries are taken. The held result and its read data stay stable.
// Reset: cfg registers clear to zero (all maps off), queue and result empty.
//   RAM contents are undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
module multi_mode_6502_address_decoder import mmad_pkg::*; #(
  parameter int unsigned LOW_RAM_DEPTH = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  mmad_stream_if.sink   req_i,
  mmad_stream_if.source rsp_o
);

  job_t dec_job;
  job_t head_job;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;

  assign req_i.ready = !q_full;
  assign push        = req_i.valid && !q_full;

  mmad_front #(
    .LOW_RAM_DEPTH(LOW_RAM_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i.payload),
    .job_o       (dec_job)
  );

  mmad_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (dec_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  mmad_back #(
    .LOW_RAM_DEPTH(LOW_RAM_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (q_pop),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp_o.payload)
  );

  a_rdata_zero_off_ram : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.payload.target != TGT_LOW && rsp_o.payload.target != TGT_HIGH
    |-> rsp_o.payload.read_data == 8'h00)
    else $error("read data nonzero for a non-RAM target");

  a_dirty_ram_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.payload.screen_dirty
    |-> rsp_o.payload.target == TGT_LOW || rsp_o.payload.target == TGT_HIGH)
    else $error("dirty pulse without a RAM target");

  a_ext_only_external : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.payload.ext_address != 16'h0000
    |-> rsp_o.payload.target == TGT_IO || rsp_o.payload.target == TGT_CART)
    else $error("external address set for an internal target");

  a_pop_needs_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

>>> tb/multi_mode_6502_address_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_mode_6502_address_decoder_test
// Drives bus accesses through all machine maps and register settings, keeps
// its own copy of both RAMs and the decode rules, and compares every result
// item field by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module multi_mode_6502_address_decoder_test;
  import mmad_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int PhaseItems  = 50;
  localparam int RandPhases  = 10;

  typedef struct packed {
    target_e     tgt;
    logic [15:0] ext;
    logic        dirty;
    logic [15:0] slot;
  } route_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  mmad_stream_if #(.payload_t(req_t)) req_if ();
  mmad_stream_if #(.payload_t(rsp_t)) rsp_if ();

  multi_mode_6502_address_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // shadow of the block's registers and RAMs
  logic [2:0]  map_sel;
  logic [15:0] win_begin;
  logic [15:0] win_end;
  logic [1:0]  wr_enables;
  bit   [7:0]  low_mem   [0:65535];
  bit          low_seen  [0:65535];
  bit   [7:0]  high_mem  [0:32767];
  bit          high_seen [0:32767];

  rsp_t        due_rsp_q[$];
  logic [15:0] written_addr_q[$];
  rsp_t        want;
  int          mismatches;
  int          idle_cycles;
  int          burst_left;
  int          rx_cycle;
  int          rx_run;
  bit          rx_hold;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic route_t decode_access(logic is_write, logic [15:0] a);
    route_t r;
    r = '{tgt: TGT_NONE, ext: 16'h0000, dirty: 1'b0, slot: 16'h0000};
    if (!is_write) begin
      case (map_sel)
        MODE_M1: begin
          if (a < 16'h8000) r.tgt = TGT_LOW;
          else if (a < 16'hC000 || a >= 16'hC100) r.tgt = TGT_HIGH;
          else begin r.tgt = TGT_IO; r.ext = {8'h00, a[7:0]}; end
        end
        MODE_M2: begin
          if (a < 16'h8000) r.tgt = TGT_LOW;
          else if (a >= 16'h9000 && a < 16'h9400) begin r.tgt = TGT_IO; r.ext = a; end
          else r.tgt = TGT_HIGH;
        end
        MODE_M3: begin
          if (a[15:8] == 8'h03) begin r.tgt = TGT_IO; r.ext = a; end
          else if (a < 16'h8000) r.tgt = TGT_LOW;
          else r.tgt = TGT_HIGH;
        end
        MODE_M4: begin
          if (a < 16'h8000) r.tgt = TGT_LOW;
          else if (a >= 16'hB000 && a < 16'hBC00) begin r.tgt = TGT_IO; r.ext = a; end
          else r.tgt = TGT_HIGH;
        end
        MODE_M5: begin
          if (a >= 16'h8000) begin r.tgt = TGT_CART; r.ext = a; end
          else if (a >= 16'h6000 || a < 16'h2000) r.tgt = TGT_LOW;
          else if (a < 16'h4000) begin r.tgt = TGT_IO; r.ext = 16'h2000 + a[2:0]; end
          else if (a <= 16'h4016) begin r.tgt = TGT_IO; r.ext = a; end
        end
        default: r.tgt = TGT_NONE;
      endcase
    end else begin
      case (map_sel)
        MODE_M1: begin
          if (a >= win_begin && a < win_end) begin r.tgt = TGT_LOW; r.dirty = 1'b1; end
          else if (a < 16'h8000) r.tgt = TGT_LOW;
          else if (a < 16'hC000) r.tgt = TGT_HIGH;
          else if (a < 16'hC100) begin r.tgt = TGT_IO; r.ext = {8'h00, a[7:0]}; end
        end
        MODE_M2: begin
          if (a < 16'h8000) r.tgt = TGT_LOW;
          else if (a >= 16'h9000 && a < 16'h9400) begin r.tgt = TGT_IO; r.ext = a; end
          else if (a >= 16'h9400 && a < 16'h9800) r.tgt = TGT_HIGH;
        end
        MODE_M3: begin
          if (a[15:8] == 8'h03) begin r.tgt = TGT_IO; r.ext = a; end
          else if (a < 16'h8000) r.tgt = TGT_LOW;
          else if (a < 16'hC000) r.tgt = TGT_HIGH;
        end
        MODE_M4: begin
          if (a < 16'h0400 || (a >= 16'h2800 && a < 16'h3C00)) r.tgt = TGT_LOW;
          else if (a >= 16'h8000 && a < 16'h9800) begin
            r.tgt   = TGT_HIGH;
            r.dirty = (a < win_end);
          end
          else if (a >= 16'hB000 && a < 16'hBC00) begin r.tgt = TGT_IO; r.ext = a; end
        end
        MODE_M5: begin
          if (a < 16'h2000) r.tgt = TGT_LOW;
          else if (a < 16'h4000) begin r.tgt = TGT_IO; r.ext = 16'h2000 + a[2:0]; end
          else if (a <= 16'h4016) begin r.tgt = TGT_IO; r.ext = a; end
          else if (a >= 16'h6000 && a < 16'h8000 && wr_enables[0]) r.tgt = TGT_LOW;
          else if (a >= 16'h8000 && wr_enables[1]) begin r.tgt = TGT_IO; r.ext = a; end
        end
        default: r.tgt = TGT_NONE;
      endcase
    end
    if (r.tgt == TGT_LOW)
      r.slot = (map_sel == MODE_M5 && a < 16'h2000) ? (a & 16'h07FF) : a;
    else if (r.tgt == TGT_HIGH)
      r.slot = a & 16'h7FFF;
    return r;
  endfunction

  // applies one access to the RAM copies and returns the result it must give
  function automatic rsp_t commit_access(req_t q);
    route_t r;
    rsp_t   e;
    r = decode_access(q.req_type, q.address);
    e.read_data    = 8'h00;
    e.target       = r.tgt;
    e.ext_address  = r.ext;
    e.screen_dirty = r.dirty;
    if (q.req_type == REQ_WRITE) begin
      if (r.tgt == TGT_LOW) begin
        low_mem[r.slot]  = q.write_data;
        low_seen[r.slot] = 1'b1;
      end else if (r.tgt == TGT_HIGH) begin
        high_mem[r.slot[14:0]]  = q.write_data;
        high_seen[r.slot[14:0]] = 1'b1;
      end
    end else if (r.tgt == TGT_LOW) begin
      e.read_data = low_mem[r.slot];
    end else if (r.tgt == TGT_HIGH) begin
      e.read_data = high_mem[r.slot[14:0]];
    end
    return e;
  endfunction

  function automatic bit readable(logic [15:0] a);
    route_t r;
    r = decode_access(REQ_READ, a);
    if (r.tgt == TGT_LOW) return low_seen[r.slot];
    if (r.tgt == TGT_HIGH) return high_seen[r.slot[14:0]];
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_address();
    logic [15:0] marks [0:20];
    logic [15:0] a;
    marks = '{16'h0000, 16'h0300, 16'h0400, 16'h0800, 16'h2000, 16'h2800, 16'h3C00,
              16'h4000, 16'h4017, 16'h6000, 16'h8000, 16'h9000, 16'h9400, 16'h9800,
              16'hB000, 16'hBC00, 16'hC000, 16'hC100, 16'hFFFF, win_begin, win_end};
    case ($urandom_range(0, 5))
      0:       a = 16'($urandom);
      1, 2:    a = marks[$urandom_range(0, 20)] + 16'($urandom_range(0, 7)) - 16'd4;
      3:       a = 16'($urandom_range(0, 16'h0FFF));
      default: begin
        if (written_addr_q.size() != 0)
          a = written_addr_q[$urandom_range(0, written_addr_q.size() - 1)];
        else
          a = 16'($urandom);
      end
    endcase
    return a;
  endfunction

  task automatic send_access(input req_t q);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    due_rsp_q.push_back(commit_access(q));
    req_if.valid   <= 1'b1;
    req_if.payload <= q;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic access(input logic wr, input logic [15:0] a, input logic [7:0] d);
    req_t q;
    q.req_type   = wr;
    q.address    = a;
    q.write_data = d;
    send_access(q);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // registers change only with nothing in flight
  task automatic set_config(input logic [2:0] mode, input logic [15:0] wb,
                            input logic [15:0] we, input logic [1:0] en);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MEMORY_MODE;
    cfg_data_i  <= {13'd0, mode};
    @(posedge clk_i);
    cfg_index_i <= CFG_WINDOW_BEGIN;
    cfg_data_i  <= wb;
    @(posedge clk_i);
    cfg_index_i <= CFG_WINDOW_END;
    cfg_data_i  <= we;
    @(posedge clk_i);
    cfg_index_i <= CFG_WRITE_ENABLES;
    cfg_data_i  <= {14'd0, en};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    map_sel     = mode;
    win_begin   = wb;
    win_end     = we;
    wr_enables  = en;
  endtask

  task automatic test_maps_off();
    access(REQ_WRITE, 16'h0000, 8'hFF);
    set_config(3'd7, 16'h0000, 16'h0000, 2'd0);
    access(REQ_READ, 16'hFFFF, 8'h00);
  endtask

  task automatic test_map_1();
    set_config(MODE_M1, 16'h0400, 16'h0800, 2'd0);
    access(REQ_WRITE, 16'h07FF, 8'hA5);
    access(REQ_WRITE, 16'h0800, 8'h5A);
    access(REQ_WRITE, 16'hBFFF, 8'h3C);
    access(REQ_WRITE, 16'hC0FF, 8'hC3);
    access(REQ_WRITE, 16'hC100, 8'hFF);
    access(REQ_READ,  16'h07FF, 8'h00);
    access(REQ_READ,  16'hBFFF, 8'h00);
  endtask

  task automatic test_map_2();
    set_config(MODE_M2, 16'h0400, 16'h0800, 2'd0);
    access(REQ_WRITE, 16'h9400, 8'h81);
    access(REQ_READ,  16'h9400, 8'h00);
    access(REQ_WRITE, 16'h9800, 8'h7E);
    access(REQ_READ,  16'h93FF, 8'h00);
  endtask

  task automatic test_map_3();
    set_config(MODE_M3, 16'h0000, 16'h0000, 2'd0);
    access(REQ_WRITE, 16'h0300, 8'h01);
    access(REQ_WRITE, 16'hC000, 8'h80);
  endtask

  task automatic test_map_4();
    set_config(MODE_M4, 16'h0000, 16'h8800, 2'd0);
    access(REQ_WRITE, 16'h87FF, 8'h99);
    access(REQ_WRITE, 16'h3C00, 8'h66);
    access(REQ_READ,  16'hBBFF, 8'h00);
  endtask

  task automatic test_map_5();
    set_config(MODE_M5, 16'h0000, 16'h0000, 2'd0);
    access(REQ_WRITE, 16'h1FFF, 8'h0F);
    access(REQ_READ,  16'h07FF, 8'h00);
    access(REQ_READ,  16'h2009, 8'h00);
    access(REQ_READ,  16'h4017, 8'h00);
    access(REQ_WRITE, 16'h6000, 8'hF0);
    set_config(MODE_M5, 16'h0000, 16'h0000, 2'd3);
    access(REQ_WRITE, 16'hFFFF, 8'h00);
  endtask

  task automatic test_random_traffic();
    req_t        q;
    int          tries;
    logic [2:0]  mode;
    logic [15:0] wb;
    logic [15:0] we;
    for (int phase = 0; phase < RandPhases; phase++) begin
      mode = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 5));
      wb   = 16'($urandom);
      we   = $urandom_range(0, 1) ? wb + 16'($urandom_range(0, 16'h1000)) : 16'($urandom);
      case (phase)
        0:       set_config(MODE_M1, 16'h0000, 16'hFFFF, 2'd0);
        1:       set_config(MODE_M1, 16'hFFFF, 16'h0000, 2'd3);
        2:       set_config(MODE_M4, 16'h0000, 16'hFFFF, 2'd1);
        3:       set_config(MODE_M5, wb, we, 2'd0);
        4:       set_config(MODE_M5, wb, we, 2'd3);
        default: set_config(mode, wb, we, 2'($urandom_range(0, 3)));
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        q.write_data = 8'($urandom_range(0, 255));
        q.req_type   = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
        q.address    = pick_address();
        tries        = 0;
        while (q.req_type == REQ_READ && !readable(q.address) && tries < 16) begin
          q.address = pick_address();
          tries++;
        end
        if (!readable(q.address)) q.req_type = REQ_WRITE;
        if (q.req_type == REQ_WRITE) begin
          written_addr_q.push_back(q.address);
          if (written_addr_q.size() > 64) void'(written_addr_q.pop_front());
        end
        send_access(q);
      end
    end
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %h, actual %h", what, exp_v, got_v);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (due_rsp_q.size() == 0) begin
        note_mismatch("unexpected item", 16'h0000, rsp_if.payload.ext_address);
      end else begin
        want = due_rsp_q.pop_front();
        if (rsp_if.payload.read_data !== want.read_data)
          note_mismatch("read_data", want.read_data, rsp_if.payload.read_data);
        if (rsp_if.payload.target !== want.target)
          note_mismatch("target", want.target, rsp_if.payload.target);
        if (rsp_if.payload.ext_address !== want.ext_address)
          note_mismatch("ext_address", want.ext_address, rsp_if.payload.ext_address);
        if (rsp_if.payload.screen_dirty !== want.screen_dirty)
          note_mismatch("screen_dirty", want.screen_dirty, rsp_if.payload.screen_dirty);
      end
    end
  end

  // receiver: always ready, then random stalls, then runs of ready and stall
  always @(posedge clk_i) begin
    rx_cycle = rx_cycle + 1;
    case ((rx_cycle / 300) % 3)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_run == 0) begin
          rx_hold = ~rx_hold;
          rx_run  = $urandom_range(1, 8);
        end
        rx_run = rx_run - 1;
        rsp_if.ready <= ~rx_hold;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_MEMORY_MODE;
    cfg_data_i     = 16'h0000;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b1;
    map_sel        = MODE_OFF;
    win_begin      = 16'h0000;
    win_end        = 16'h0000;
    wr_enables     = 2'd0;
    mismatches     = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    rx_cycle       = 0;
    rx_run         = 0;
    rx_hold        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_maps_off();
    test_map_1();
    test_map_2();
    test_map_3();
    test_map_4();
    test_map_5();
    test_random_traffic();

    drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && due_rsp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> multi_mode_6502_address_decoder.f
hdl/mmad_pkg.sv
hdl/mmad_stream_if.sv
hdl/mmad_front.sv
hdl/mmad_queue.sv
hdl/mmad_back.sv
hdl/multi_mode_6502_address_decoder.sv
tb/multi_mode_6502_address_decoder_test.sv
